// ----- sv/temporal_history_id_registry_unit_macros.svh -----
// assertion macros for the history id registry
`ifndef TEMPORAL_HISTORY_ID_REGISTRY_UNIT_MACROS_SVH
`define TEMPORAL_HISTORY_ID_REGISTRY_UNIT_MACROS_SVH

// same-cycle implication
`define THIR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thir assertion failed");

// next-cycle implication
`define THIR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thir assertion failed");

`endif

// ----- sv/thir_pkg.sv -----
// types and constants shared by the history id registry
`default_nettype none
package thir_pkg;

  typedef enum logic [1:0] {
    OP_ACQUIRE    = 2'd0,
    OP_INVALIDATE = 2'd1,
    OP_PRUNE      = 2'd2,
    OP_CLEAR      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [63:0] feature;
    logic [63:0] view;
    logic [31:0] origin;
    logic [63:0] size;
    logic [63:0] guides;
    logic [63:0] hid;
    logic [63:0] last_seen;
    logic [63:0] last_reset;
  } entry_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] feature;
    logic [63:0] view;
    logic [63:0] frame;
    logic [63:0] max_idle;
  } req_t;

  typedef struct packed {
    logic   active;
    logic   hit;
    logic   free;
    entry_t hit_entry;
  } tok_t;

  typedef struct packed {
    logic   en;
    entry_t entry;
  } wr_t;

endpackage
`default_nettype wire

// ----- sv/thir_if.sv -----
// channel interfaces of the history id registry
`default_nettype none
interface thir_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] feature_key;
  logic [63:0] view_key;
  logic [63:0] frame_number;
  logic [15:0] view_x;
  logic [15:0] view_y;
  logic [15:0] view_width;
  logic [15:0] view_height;
  logic [15:0] out_width;
  logic [15:0] out_height;
  logic [63:0] guide_signature;
  logic        reset_requested;
  modport source (output valid, opcode, feature_key, view_key, frame_number, view_x,
                  view_y, view_width, view_height, out_width, out_height,
                  guide_signature, reset_requested, input ready);
  modport sink (input valid, opcode, feature_key, view_key, frame_number, view_x,
                view_y, view_width, view_height, out_width, out_height,
                guide_signature, reset_requested, output ready);
endinterface

interface thir_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] history_id;
  logic        history_reset;
  logic [1:0]  status;
  modport source (output valid, history_id, history_reset, status, input ready);
  modport sink (input valid, history_id, history_reset, status, output ready);
endinterface

interface thir_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] max_idle_frames;
  modport source (output valid, max_idle_frames, input ready);
  modport sink (input valid, max_idle_frames, output ready);
endinterface
`default_nettype wire

// ----- sv/temporal_history_id_registry_unit.sv -----
// top level: history id registry with a chain of entry cells
// the result is registered once the scan token has passed every cell; a new
// transaction is taken only in idle, after the last result is registered, and the scan token
//   steps one cell per cycle through the chain
// reset: table empty, next identity one, idle limit zero, no clearing pass
`default_nettype none
module temporal_history_id_registry_unit
  import thir_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input wire logic clk,
  input wire logic rst_n,
  thir_in_if.sink    in_ch,
  thir_out_if.source out_ch,
  thir_cfg_if.sink   cfg_ch
);

  `include "temporal_history_id_registry_unit_macros.svh"

  localparam int IW = $clog2(TABLE_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE} state_t;

  state_t        state_r;
  logic          start_r;
  req_t          req_r;
  entry_t        nent_r;
  logic          rreq_r;
  logic [63:0]   max_idle_r;
  logic [63:0]   next_id_r, nid_nxt;
  logic          out_valid_r;
  logic [63:0]   out_id_r, res_id;
  logic          out_rst_r, res_rst;
  status_t       out_st_r, res_st;
  wr_t           wr;
  logic [IW-1:0] wr_idx;
  logic          accept, go;
  logic          need, grant_ok;
  entry_t        he, upd;
  tok_t          sc_tok_r;
  logic [IW-1:0] sc_hidx_r, sc_fidx_r;

  tok_t          tok   [TABLE_ENTRIES+1];
  logic [IW-1:0] hidx  [TABLE_ENTRIES+1];
  logic [IW-1:0] fidx  [TABLE_ENTRIES+1];

  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign go           = (state_r == S_DECIDE) && (!out_valid_r || out_ch.ready);

  assign tok[0]  = '{active: start_r, hit: 1'b0, free: 1'b0, hit_entry: '0};
  assign hidx[0] = '0;
  assign fidx[0] = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    thir_cell #(.IW(IW), .IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .req(req_r), .wr(wr), .wr_idx(wr_idx),
      .tok_in(tok[g]), .hidx_in(hidx[g]), .fidx_in(fidx[g]),
      .tok_out(tok[g+1]), .hidx_out(hidx[g+1]), .fidx_out(fidx[g+1])
    );
  end

  assign he       = sc_tok_r.hit_entry;
  assign grant_ok = (next_id_r != 64'd0);
  assign need     = rreq_r || he.origin != nent_r.origin || he.size != nent_r.size ||
                    (!rreq_r && he.guides != nent_r.guides);

  always_comb begin
    res_id   = '0;
    res_rst  = 1'b0;
    res_st   = ST_OK;
    nid_nxt  = next_id_r;
    wr.en    = 1'b0;
    wr.entry = nent_r;
    wr_idx   = sc_fidx_r;
    upd      = he;
    wr.entry.hid = next_id_r;
    if (req_r.op == OP_ACQUIRE) begin
      if (req_r.feature == 64'd0 ||
          (sc_tok_r.hit && req_r.frame < he.last_seen)) begin
        if (grant_ok) begin
          res_id  = next_id_r;
          res_rst = 1'b1;
          nid_nxt = next_id_r + 64'd1;
        end else begin
          res_st = ST_EXHAUSTED;
        end
      end else if (!sc_tok_r.hit) begin
        if (grant_ok) begin
          res_id  = next_id_r;
          res_rst = 1'b1;
          nid_nxt = next_id_r + 64'd1;
          if (sc_tok_r.free) wr.en = go;
          else res_st = ST_FULL;
        end else begin
          res_st = ST_EXHAUSTED;
        end
      end else begin
        if (need && he.last_reset != req_r.frame && !grant_ok) begin
          res_st = ST_EXHAUSTED;
        end else begin
          if (need && he.last_reset != req_r.frame) begin
            upd.hid        = next_id_r;
            upd.last_reset = req_r.frame;
            nid_nxt        = next_id_r + 64'd1;
          end
          if (need) begin
            upd.origin = nent_r.origin;
            upd.size   = nent_r.size;
          end
          if (!rreq_r) upd.guides = nent_r.guides;
          upd.last_seen = req_r.frame;
          wr.en    = go;
          wr.entry = upd;
          wr_idx   = sc_hidx_r;
          res_id   = upd.hid;
          res_rst  = need;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      next_id_r   <= 64'd1;
      max_idle_r  <= '0;
    end else begin
      start_r <= accept;
      if (cfg_ch.valid) max_idle_r <= cfg_ch.max_idle_frames;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (tok[TABLE_ENTRIES].active) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (go) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            next_id_r   <= nid_nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    // hold the scan outcome once the token leaves the chain
    if (state_r == S_SCAN && tok[TABLE_ENTRIES].active) begin
      sc_tok_r  <= tok[TABLE_ENTRIES];
      sc_hidx_r <= hidx[TABLE_ENTRIES];
      sc_fidx_r <= fidx[TABLE_ENTRIES];
    end
    if (accept) begin
      req_r.op        <= op_t'(in_ch.opcode);
      req_r.feature   <= in_ch.feature_key;
      req_r.view      <= in_ch.view_key;
      req_r.frame     <= in_ch.frame_number;
      req_r.max_idle  <= max_idle_r;
      rreq_r          <= in_ch.reset_requested;
      nent_r.feature  <= in_ch.feature_key;
      nent_r.view     <= in_ch.view_key;
      nent_r.origin   <= {in_ch.view_y, in_ch.view_x};
      nent_r.size     <= {in_ch.out_height, in_ch.out_width, in_ch.view_height,
                          in_ch.view_width};
      nent_r.guides   <= in_ch.guide_signature;
      nent_r.hid      <= '0;
      nent_r.last_seen  <= in_ch.frame_number;
      nent_r.last_reset <= in_ch.frame_number;
    end
    if (go) begin
      out_id_r  <= res_id;
      out_rst_r <= res_rst;
      out_st_r  <= res_st;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.history_id    = out_id_r;
  assign out_ch.history_reset = out_rst_r;
  assign out_ch.status        = out_st_r;

  `THIR_ASSERT_NEXT(a_accept_scan, accept, state_r == S_SCAN)
  `THIR_ASSERT_NOW(a_tok_in_scan, tok[TABLE_ENTRIES].active, state_r == S_SCAN)
  `THIR_ASSERT_NOW(a_wr_in_decide, wr.en, go)
  `THIR_ASSERT_NOW(a_exh_zero, out_valid_r && out_st_r == ST_EXHAUSTED,
                   out_id_r == 64'd0 && !out_rst_r)

endmodule
`default_nettype wire

// ----- sv/thir_cell.sv -----
// one table entry of the registry, passes the scan token to its neighbor
`default_nettype none
module thir_cell
  import thir_pkg::*;
#(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire req_t          req,
  input  wire wr_t           wr,
  input  wire logic [IW-1:0] wr_idx,
  input  wire tok_t          tok_in,
  input  wire logic [IW-1:0] hidx_in,
  input  wire logic [IW-1:0] fidx_in,
  output tok_t               tok_out,
  output logic [IW-1:0]      hidx_out,
  output logic [IW-1:0]      fidx_out
);

  logic          valid_r, valid_nxt;
  entry_t        ent_r;
  tok_t          tok_r, tok_nxt;
  logic [IW-1:0] hidx_r, hidx_nxt;
  logic [IW-1:0] fidx_r, fidx_nxt;
  logic          mine;
  logic [63:0]   age;

  assign mine = wr.en && (wr_idx == IW'(IDX));
  assign age  = req.frame - ent_r.last_seen;

  always_comb begin
    valid_nxt = valid_r;
    tok_nxt   = tok_in;
    hidx_nxt  = hidx_in;
    fidx_nxt  = fidx_in;
    if (mine) begin
      valid_nxt = 1'b1;
    end
    if (tok_in.active) begin
      case (req.op)
        OP_ACQUIRE: begin
          if (valid_r) begin
            if (!tok_in.hit && ent_r.feature == req.feature && ent_r.view == req.view) begin
              tok_nxt.hit       = 1'b1;
              tok_nxt.hit_entry = ent_r;
              hidx_nxt          = IW'(IDX);
            end
          end else if (!tok_in.free) begin
            tok_nxt.free = 1'b1;
            fidx_nxt     = IW'(IDX);
          end
        end
        OP_INVALIDATE: begin
          if (ent_r.feature == req.feature) valid_nxt = 1'b0;
        end
        OP_PRUNE: begin
          if (req.frame >= ent_r.last_seen && age > req.max_idle) valid_nxt = 1'b0;
        end
        default: begin
          valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      tok_r.active <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
    hidx_r <= hidx_nxt;
    fidx_r <= fidx_nxt;
    if (mine) ent_r <= wr.entry;
  end

  assign tok_out  = tok_r;
  assign hidx_out = hidx_r;
  assign fidx_out = fidx_r;

endmodule
`default_nettype wire
